// ===== rtl/core/qsed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted string escape decoder package
// Shared types, constants and helpers for the decoder front, queue and back.
// ----------------------------------------------------------------------------
package qsed_pkg;

   localparam int COUNT_BITS  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_QUOTE  = 2'd1;
   localparam logic [1:0] KIND_NUL    = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  kind;
      logic [15:0] consumed;
      logic        last;
   } rsp_type;

   typedef struct packed {
      rsp_type r0;
      logic    r1_valid;
      rsp_type r1;
   } rec_type;

   function automatic logic [15:0] sat_consumed(logic [COUNT_BITS-1:0] c);
      if (c > COUNT_BITS'(16'hFFFF)) begin
         return 16'hFFFF;
      end
      return 16'(c);
   endfunction

   function automatic rsp_type make_rsp(logic [7:0] b, logic [1:0] k, logic [15:0] cons);
      rsp_type r;
      r.out_byte = b;
      r.kind     = k;
      r.consumed = cons;
      r.last     = 1'b0;
      return r;
   endfunction

endpackage

// ===== rtl/core/qsed_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder front end
// Accepts source bytes, tracks the escape state and forms the results of
// each transaction as one record for the queue.
// ----------------------------------------------------------------------------
module qsed_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  qsed_pkg::req_type  req,
   output logic               rec_push,
   output qsed_pkg::rec_type  rec
);
   import qsed_pkg::*;

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_STR  = 5'b00010,
      MODE_ESC  = 5'b00100,
      MODE_OCT  = 5'b01000,
      MODE_HEX  = 5'b10000
   } mode_type;

   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_X      = 8'h78;

   mode_type              mode_ff, mode_in;
   logic [7:0]            accum_ff, accum_in;
   logic [1:0]            dc_ff, dc_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   logic [7:0]            b;
   logic [COUNT_BITS-1:0] cnt_plus;
   logic                  is_oct, is_hex;
   logic [3:0]            hex_val;
   logic [7:0]            esc_val;
   logic                  str_valid;
   rsp_type               str_res;
   mode_type              str_mode;
   logic                  v0, v1;
   rsp_type               r0, r1;

   assign b        = req.in_byte;
   assign cnt_plus = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_BITS'(1);
   assign is_oct   = (b >= 8'h30) && (b <= 8'h37);

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if ((b >= 8'h30) && (b <= 8'h39)) begin
         hex_val = b[3:0];
      end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
         hex_val = 4'(b[2:0] + 3'd1) + 4'd8;
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      unique case (b)
         8'h61:   esc_val = 8'h07;
         8'h62:   esc_val = 8'h08;
         8'h66:   esc_val = 8'h0C;
         8'h6E:   esc_val = 8'h0A;
         8'h72:   esc_val = 8'h0D;
         8'h74:   esc_val = 8'h09;
         8'h76:   esc_val = 8'h0B;
         8'h3F:   esc_val = 8'h3F;
         8'h27:   esc_val = 8'h27;
         8'h22:   esc_val = 8'h22;
         default: esc_val = CHR_BSLASH;
      endcase
   end

   // Handling of a byte as an ordinary string byte.
   always_comb begin
      str_valid = 1'b1;
      str_mode  = MODE_STR;
      str_res   = make_rsp(b, KIND_DATA, 16'd0);
      priority if (b == CHR_QUOTE) begin
         str_res  = make_rsp(8'd0, KIND_QUOTE, sat_consumed(cnt_plus));
         str_mode = MODE_IDLE;
      end else if (b == CHR_NUL) begin
         str_res  = make_rsp(8'd0, KIND_NUL, sat_consumed(cnt_plus));
         str_mode = MODE_IDLE;
      end else if (b == CHR_BSLASH) begin
         str_valid = 1'b0;
         str_mode  = MODE_ESC;
      end else begin
         str_valid = 1'b1;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      accum_in = accum_ff;
      dc_in    = dc_ff;
      cnt_in   = cnt_ff;
      v0       = 1'b0;
      v1       = 1'b0;
      r0       = '0;
      r1       = '0;
      if (req.first) begin
         accum_in = 8'd0;
         dc_in    = 2'd0;
         if (b == CHR_QUOTE) begin
            cnt_in  = COUNT_BITS'(1);
            mode_in = MODE_STR;
         end else begin
            cnt_in  = '0;
            v0      = 1'b1;
            r0      = make_rsp(8'd0, KIND_REJECT, 16'd0);
            mode_in = MODE_IDLE;
         end
      end else begin
         unique case (mode_ff)
            MODE_STR: begin
               cnt_in  = cnt_plus;
               mode_in = str_mode;
               v0      = str_valid;
               r0      = str_res;
            end
            MODE_ESC: begin
               if (b == CHR_NUL) begin
                  v0      = 1'b1;
                  r0      = make_rsp(8'd0, KIND_NUL, sat_consumed(cnt_ff));
                  mode_in = MODE_IDLE;
               end else begin
                  cnt_in  = cnt_plus;
                  mode_in = MODE_STR;
                  if (b == CHR_X) begin
                     mode_in  = MODE_HEX;
                     accum_in = 8'd0;
                     dc_in    = 2'd0;
                  end else if (is_oct) begin
                     mode_in  = MODE_OCT;
                     accum_in = {5'd0, b[2:0]};
                     dc_in    = 2'd1;
                  end else begin
                     v0 = 1'b1;
                     r0 = make_rsp(esc_val, KIND_DATA, 16'd0);
                  end
               end
            end
            MODE_OCT: begin
               if (is_oct) begin
                  cnt_in   = cnt_plus;
                  accum_in = {accum_ff[4:0], b[2:0]};
                  dc_in    = dc_ff + 2'd1;
                  if (dc_ff == 2'd2) begin
                     v0      = 1'b1;
                     r0      = make_rsp({accum_ff[4:0], b[2:0]}, KIND_DATA, 16'd0);
                     mode_in = MODE_STR;
                  end
               end else begin
                  v0      = 1'b1;
                  r0      = make_rsp(accum_ff, KIND_DATA, 16'd0);
                  cnt_in  = cnt_plus;
                  mode_in = str_mode;
                  v1      = str_valid;
                  r1      = str_res;
               end
            end
            MODE_HEX: begin
               if ((b == CHR_NUL) && (dc_ff == 2'd0)) begin
                  v0      = 1'b1;
                  r0      = make_rsp(8'd0, KIND_NUL, sat_consumed(cnt_ff));
                  mode_in = MODE_IDLE;
               end else if (is_hex) begin
                  cnt_in   = cnt_plus;
                  accum_in = {accum_ff[3:0], hex_val};
                  dc_in    = dc_ff + 2'd1;
                  if (dc_ff == 2'd1) begin
                     v0      = 1'b1;
                     r0      = make_rsp({accum_ff[3:0], hex_val}, KIND_DATA, 16'd0);
                     mode_in = MODE_STR;
                  end
               end else begin
                  v0      = 1'b1;
                  r0      = make_rsp(accum_ff, KIND_DATA, 16'd0);
                  cnt_in  = cnt_plus;
                  mode_in = str_mode;
                  v1      = str_valid;
                  r1      = str_res;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
      if (v1) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
   end

   assign rec_push    = accept && v0;
   assign rec.r0       = r0;
   assign rec.r1_valid = v1;
   assign rec.r1       = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         accum_ff <= 8'd0;
         dc_ff    <= 2'd0;
         cnt_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         dc_ff    <= dc_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/qsed_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record queue
// Short first-in first-out buffer of result records between front and back.
// ----------------------------------------------------------------------------
module qsed_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qsed_pkg::rec_type  push_rec,
   output logic               q_full,
   input  logic               q_pop,
   output logic               q_valid,
   output qsed_pkg::rec_type  head_rec
);
   import qsed_pkg::*;

   rec_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_full   = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign head_rec = entry_ff[rd_ptr_ff];
   assign do_push  = push && !q_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/qsed_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder back end
// Unpacks queued records into single results and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
module qsed_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  qsed_pkg::rec_type  head_rec,
   output logic               q_pop,
   output qsed_pkg::rsp_type  rsp_data,
   output logic               empty,
   input  logic               pop
);
   import qsed_pkg::*;

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type sec_ff, sec_in;
   logic    sec_valid_ff, sec_valid_in;
   logic    out_take;

   assign out_take = !out_valid_ff || pop;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      sec_in       = sec_ff;
      sec_valid_in = sec_valid_ff;
      q_pop        = 1'b0;
      if (out_take) begin
         priority if (sec_valid_ff) begin
            out_in       = sec_ff;
            out_valid_in = 1'b1;
            sec_valid_in = 1'b0;
         end else if (q_valid) begin
            out_in       = head_rec.r0;
            out_valid_in = 1'b1;
            sec_in       = head_rec.r1;
            sec_valid_in = head_rec.r1_valid;
            q_pop        = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   assign rsp_data = out_ff;
   assign empty    = !out_valid_ff;

endmodule

// ===== rtl/core/quoted_string_escape_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted string escape decoder
// Decodes a double-quoted C-style string literal arriving one byte per
// transaction into data bytes and an end or reject report.
// ----------------------------------------------------------------------------
// Usage:
// Source bytes enter through a queue-style port: a transaction is taken at a
// clock edge with push high and full low. Set first on the opening quote of
// each string. Results leave through a second queue-style port: while empty
// is low the oldest result sits on rsp_data, and it is taken at an edge with
// pop high. A byte gives zero, one or two results; last marks its final one.
// The front takes one byte every cycle while full is low; the back delivers
// one result per cycle unless the receiver stalls, so a byte with two
// results holds the back longer, absorbed by the four-record queue between
// front and back. When the receiver stalls, the queue fills and full rises.
// Synchronous reset returns the decoder to idle, empties the queue and drops
// any pending results.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  qsed_pkg::req_type  req_data,
   output logic               empty,
   input  logic               pop,
   output qsed_pkg::rsp_type  rsp_data
);
   import qsed_pkg::*;

   logic    accept;
   logic    rec_push;
   rec_type push_rec;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   rec_type head_rec;

   assign full   = q_full;
   assign accept = push && !q_full;

   qsed_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .rec_push (rec_push),
      .rec      (push_rec)
   );

   qsed_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (push_rec),
      .q_full   (q_full),
      .q_pop    (q_pop),
      .q_valid  (q_valid),
      .head_rec (head_rec)
   );

   qsed_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .head_rec (head_rec),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule
